[design/mbam_pkg.sv]
// Package: shared types and constants for the Modbus ASCII master.
`default_nettype none
package mbam_pkg;
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_CHAR  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CSUM    = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  localparam logic [7:0] FC_READ_BITS = 8'd1;
  localparam logic [7:0] FC_READ_REGS = 8'd3;
  localparam logic [7:0] FC_WRITE_REG = 8'd6;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [0:0] REG_SLAVE   = 1'd0;
  localparam logic [0:0] REG_TIMEOUT = 1'd1;

  typedef enum logic [1:0] {PH_IDLE, PH_WAIT, PH_RECV} phase_t;

  // Classified work for the back end.
  typedef struct packed {
    logic       start;
    logic [7:0] function_code;
    logic [15:0] reg_address;
    logic [15:0] reg_data;
    logic       fin;
    logic [1:0] status;
    logic [15:0] read_value;
  } job_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_char;
    logic       last;
    logic [1:0] status;
    logic [15:0] read_value;
  } res_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    hex_char = (d < 4'd10) ? (8'h30 + {4'd0, d}) : (8'h41 + {4'd0, d} - 8'd10);
  endfunction

  // Bit 4 set when the character is a hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    hex_val = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) hex_val = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) hex_val = {1'b1, 4'(c - 8'h41 + 8'd10)};
    else if (c >= 8'h61 && c <= 8'h66) hex_val = {1'b1, 4'(c - 8'h61 + 8'd10)};
  endfunction
endpackage
`default_nettype wire

[design/mbam_if.sv]
// Interfaces: request and result channels.
`default_nettype none
interface mbam_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  function_code;
  logic [15:0] reg_address;
  logic [15:0] reg_data;
  logic [7:0]  rx_char;
  modport source (output valid, op, function_code, reg_address, reg_data, rx_char,
                  input ready);
  modport sink (input valid, op, function_code, reg_address, reg_data, rx_char,
                output ready);
endinterface

interface mbam_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tx_char;
  logic        last;
  logic [1:0]  status;
  logic [15:0] read_value;
  modport source (output valid, kind, tx_char, last, status, read_value, input ready);
  modport sink (input valid, kind, tx_char, last, status, read_value, output ready);
endinterface
`default_nettype wire

[design/mbam_front.sv]
// Front end: receive parser, timeout counter and frame checks.
`default_nettype none
module mbam_front import mbam_pkg::*; #(
  parameter int MAX_FRAME_CHARS = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [7:0]  function_code,
  input  wire logic [15:0] reg_address,
  input  wire logic [15:0] reg_data,
  input  wire logic [7:0]  rx_char,
  input  wire logic [7:0]  slave_address,
  input  wire logic [15:0] timeout_ticks,
  output logic             job_valid,
  input  wire logic        job_ready,
  output job_t             job
);
  localparam int CW = $clog2(MAX_FRAME_CHARS + 1);

  phase_t      phase;
  logic [7:0]  lrc_sum;
  logic [7:0]  frame_bytes [6];
  logic [4:0]  high_nibble;
  logic [6:0]  byte_count;
  logic [CW-1:0] char_count;
  logic        saw_cr, bad_frame, hex_done;
  logic [15:0] tick_count;
  logic [7:0]  p_fc;
  logic [15:0] p_addr, p_data;

  logic        acc;
  logic [4:0]  hv;
  logic [7:0]  new_byte;
  logic [1:0]  jst;
  logic [15:0] jval;
  logic        frame_end;

  assign in_ready = job_ready;
  assign acc = in_valid && in_ready;
  assign hv = hex_val(rx_char);
  assign new_byte = {high_nibble[3:0], hv[3:0]};
  assign frame_end = (rx_char == CH_LF) && saw_cr;

  // Frame judgement from the stored state; char_count here is before this LF.
  always_comb begin
    jst = ST_OK;
    jval = 16'd0;
    if (char_count + CW'(1) < CW'(11)) jst = ST_INVALID;
    else if (bad_frame || high_nibble[4] || byte_count > 7'd64 || byte_count < 7'd4)
      jst = ST_INVALID;
    else if (lrc_sum != 8'd0) jst = ST_CSUM;
    else if (frame_bytes[0] != slave_address) jst = ST_INVALID;
    else if (frame_bytes[1][7]) jst = ST_INVALID;
    else if (frame_bytes[1] != p_fc) jst = ST_INVALID;
    else if (p_fc == FC_WRITE_REG) begin
      if (byte_count < 7'd7 || {frame_bytes[2], frame_bytes[3]} != p_addr ||
          {frame_bytes[4], frame_bytes[5]} != p_data) jst = ST_INVALID;
    end else if (p_fc == FC_READ_REGS) begin
      if (byte_count < 7'd6 || frame_bytes[2] != 8'd2) jst = ST_INVALID;
      else jval = {frame_bytes[3], frame_bytes[4]};
    end else if (p_fc == FC_READ_BITS) begin
      if (byte_count < 7'd5 || frame_bytes[2] != 8'd1) jst = ST_INVALID;
      else jval = {15'd0, frame_bytes[3][0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      lrc_sum <= '0; high_nibble <= '0; byte_count <= '0; char_count <= '0;
      saw_cr <= 1'b0; bad_frame <= 1'b0; hex_done <= 1'b0; tick_count <= '0;
      p_fc <= '0; p_addr <= '0; p_data <= '0;
      job_valid <= 1'b0;
    end else begin
      if (job_ready) job_valid <= 1'b0;
      if (acc) begin
        case (op)
          OP_START: begin
            p_fc <= function_code; p_addr <= reg_address; p_data <= reg_data;
            tick_count <= '0;
            phase <= PH_WAIT;
            job_valid <= 1'b1;
            job <= '{start: 1'b1, function_code: function_code,
                     reg_address: reg_address, reg_data: reg_data,
                     fin: 1'b0, status: ST_OK, read_value: 16'd0};
          end
          OP_TICK: begin
            if (phase != PH_IDLE) begin
              if (tick_count >= timeout_ticks) begin
                phase <= PH_IDLE;
                job_valid <= 1'b1;
                job <= '{start: 1'b0, function_code: 8'd0, reg_address: 16'd0,
                         reg_data: 16'd0, fin: 1'b1, status: ST_TIMEOUT,
                         read_value: 16'd0};
              end else tick_count <= tick_count + 16'd1;
            end
          end
          OP_CHAR: begin
            if (phase == PH_WAIT) begin
              if (rx_char == CH_COLON) begin
                lrc_sum <= '0; high_nibble <= '0; byte_count <= '0;
                char_count <= CW'(1);
                saw_cr <= 1'b0; bad_frame <= 1'b0; hex_done <= 1'b0;
                phase <= PH_RECV;
              end
            end else if (phase == PH_RECV) begin
              char_count <= char_count + CW'(1);
              if (frame_end) begin
                phase <= PH_IDLE;
                job_valid <= 1'b1;
                job <= '{start: 1'b0, function_code: 8'd0, reg_address: 16'd0,
                         reg_data: 16'd0, fin: 1'b1, status: jst, read_value: jval};
              end else begin
                if (!hex_done) begin
                  if (rx_char == CH_CR) hex_done <= 1'b1;
                  else if (!hv[4]) bad_frame <= 1'b1;
                  else if (high_nibble[4]) begin
                    if (byte_count < 7'd6) frame_bytes[byte_count[2:0]] <= new_byte;
                    lrc_sum <= lrc_sum + new_byte;
                    if (byte_count < 7'd127) byte_count <= byte_count + 7'd1;
                    high_nibble <= '0;
                  end else high_nibble <= hv;
                end
                saw_cr <= (rx_char == CH_CR);
                // Drop the frame as invalid once the character count reaches MAX_FRAME_CHARS - 1.
                if (char_count + CW'(1) >= CW'(MAX_FRAME_CHARS - 1)) begin
                  phase <= PH_IDLE;
                  job_valid <= 1'b1;
                  job <= '{start: 1'b0, function_code: 8'd0, reg_address: 16'd0,
                           reg_data: 16'd0, fin: 1'b1, status: ST_INVALID,
                           read_value: 16'd0};
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

[design/mbam_queue.sv]
// Queue: short FIFO of jobs between front and back end.
`default_nettype none
module mbam_queue import mbam_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  job_t      in_job,
  output logic      out_valid,
  input  wire logic out_ready,
  output job_t      out_job
);
  job_t       mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push, pop;

  assign in_ready = cnt != 2'd2;
  assign out_valid = cnt != 2'd0;
  assign out_job = mem[rp];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_job;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

[design/mbam_back.sv]
// Back end: serializes request frames and finish results.
`default_nettype none
module mbam_back import mbam_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] slave_address,
  input  wire logic       job_valid,
  output logic            job_ready,
  input  job_t            job,
  output logic            res_valid,
  input  wire logic       res_ready,
  output res_t            res
);
  logic [4:0] idx;
  logic [7:0] b [7];
  logic [7:0] sum;
  logic [7:0] ch;
  logic [2:0] bi;
  logic       emit, last_ch;

  // Frame bytes: address, function, register, data, LRC.
  always_comb begin
    b[0] = slave_address; b[1] = job.function_code;
    b[2] = job.reg_address[15:8]; b[3] = job.reg_address[7:0];
    b[4] = job.reg_data[15:8]; b[5] = job.reg_data[7:0];
    sum = b[0] + b[1] + b[2] + b[3] + b[4] + b[5];
    b[6] = 8'd0 - sum;
    bi = 3'((idx - 5'd1) >> 1);
    if (idx == 5'd0) ch = CH_COLON;
    else if (idx == 5'd15) ch = CH_CR;
    else if (idx == 5'd16) ch = CH_LF;
    else ch = idx[0] ? hex_char(b[bi][7:4]) : hex_char(b[bi][3:0]);
  end

  assign emit = job_valid && (!res_valid || res_ready);
  assign last_ch = job.fin || idx == 5'd16;
  assign job_ready = emit && last_ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0; res_valid <= 1'b0;
    end else begin
      if (res_ready) res_valid <= 1'b0;
      if (emit) begin
        res_valid <= 1'b1;
        idx <= last_ch ? 5'd0 : idx + 5'd1;
        if (job.fin) res <= '{kind: 1'b1, tx_char: 8'd0, last: 1'b0,
                               status: job.status, read_value: job.read_value};
        else res <= '{kind: 1'b0, tx_char: ch, last: idx == 5'd16,
                      status: ST_OK, read_value: 16'd0};
      end
    end
  end
endmodule
`default_nettype wire

[design/modbus_ascii_master_transaction.sv]
// Top level: Modbus ASCII master transaction engine.
//
//  channel | dir | content
//  req     | in  | op, function_code, reg_address, reg_data, rx_char
//  res     | out | kind, tx_char, last, status, read_value
//  cfg     | in  | cfg_we, cfg_index, cfg_data (slave_address, timeout_ticks)
//
// One request per cycle enters the front end, which parses received characters,
// counts ticks and judges frames in that cycle. Starts and finishes go to a
// two-entry queue; the back end turns a start into 17 characters, one per cycle
// while the result register is free or being taken, and a finish into one result.
// Reset is synchronous: idle, registers to 1 and 1000. Requests stall only when
// the queue is full; the result register holds while res.ready is low.
`default_nettype none
module modbus_ascii_master_transaction import mbam_pkg::*; #(
  parameter int MAX_FRAME_CHARS = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  mbam_req_if.sink         req,
  mbam_res_if.source       res,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  logic [7:0]  slave_address;
  logic [15:0] timeout_ticks;
  logic        f_valid, f_ready, q_valid, q_ready;
  job_t        f_job, q_job;
  res_t        r;

  // Hold configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'd1;
      timeout_ticks <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SLAVE:   slave_address <= cfg_data[7:0];
        REG_TIMEOUT: timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  mbam_front #(.MAX_FRAME_CHARS(MAX_FRAME_CHARS)) u_front (
    .clk, .rst,
    .in_valid(req.valid), .in_ready(req.ready), .op(req.op),
    .function_code(req.function_code), .reg_address(req.reg_address),
    .reg_data(req.reg_data), .rx_char(req.rx_char),
    .slave_address, .timeout_ticks,
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  mbam_queue u_queue (
    .clk, .rst, .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
    .out_valid(q_valid), .out_ready(q_ready), .out_job(q_job)
  );

  mbam_back u_back (
    .clk, .rst, .slave_address,
    .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
    .res_valid(res.valid), .res_ready(res.ready), .res(r)
  );

  assign res.kind = r.kind;
  assign res.tx_char = r.tx_char;
  assign res.last = r.last;
  assign res.status = r.status;
  assign res.read_value = r.read_value;
endmodule
`default_nettype wire
